### rtl/core/fixed_point_alu_assert.svh
// Assertion macros shared by the fixed-point ALU.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted.
`define FPALU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fixed_point_alu: check failed");

// Next-cycle implication, sampled on aclk, off while reset is asserted.
`define FPALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fixed_point_alu: check failed");

`endif

### rtl/core/fpalu_pkg.sv
// Opcodes and status codes of the fixed-point ALU.
package fpalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_LT  = 4'd4,
        OP_GT  = 4'd5,
        OP_LE  = 4'd6,
        OP_GE  = 4'd7,
        OP_EQ  = 4'd8,
        OP_NE  = 4'd9,
        OP_MIN = 4'd10,
        OP_MAX = 4'd11,
        OP_INC = 4'd12,
        OP_DEC = 4'd13,
        OP_I2F = 4'd14,
        OP_F2I = 4'd15
    } opcode_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

endpackage

### rtl/core/fixed_point_alu.sv
// Pipelined signed fixed-point ALU with a one-bit-per-stage divider.
//
//  Channel | Direction | Ports                                           | Beat
//  --------+-----------+-------------------------------------------------+------------------
//  s_      | in        | s_opcode, s_operand_a, s_operand_b              | one operation
//  m_      | out       | m_result_value, m_compare_flag, m_status        | one result
//
// One beat is accepted every cycle while the output stage is empty or being taken; results
// leave in the order their operations were taken.
// The pipeline depth is set by the restoring divider, which resolves one quotient bit per stage.
// All stages advance together whenever the output stage is empty or being taken.
// Reset clears the valid bit of every stage; the data registers are not reset.
module fixed_point_alu #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic               m_compare_flag,
    output logic [1:0]         m_status
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + F;
    localparam int D  = NW;
    localparam int Z  = D + 3;
    localparam int H  = (W + 1) / 2;
    localparam int PW = 4 * H;
    localparam int MW = (2 * W > NW) ? 2 * W : NW;
    localparam logic [W-1:0] SAT_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_NEG = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic                vld;
        fpalu_pkg::opcode_t  op;
        logic [W-1:0]        a;
        logic [W-1:0]        b;
        logic [W-1:0]        ma;
        logic [W-1:0]        mb;
        logic                rneg;
        logic [W-1:0]        res;
        logic                flag;
        logic [1:0]          status;
        logic [2*H-1:0]      pll;
        logic [2*H-1:0]      plh;
        logic [2*H-1:0]      phl;
        logic [2*H-1:0]      phh;
        logic [2*W-1:0]      prod;
        logic [W-1:0]        rem;
        logic [NW-1:0]       quo;
    } stage_t;

    function automatic logic [W:0] fit(input logic neg, input logic [MW-1:0] m);
        logic [MW-1:0] lim;
        logic [W-1:0]  v;
        lim = (MW'(1) << (W - 1)) - (neg ? MW'(0) : MW'(1));
        v   = W'(m);
        if (m > lim) begin
            fit = {1'b1, (neg ? SAT_NEG : SAT_POS)};
        end else begin
            fit = {1'b0, (neg ? (~v) + W'(1) : v)};
        end
    endfunction

    stage_t       stg_reg  [1:Z];
    stage_t       stg_next [1:Z];
    logic         adv;
    logic [W-1:0] op_a_w;
    logic [W-1:0] op_b_w;

    assign adv     = !stg_reg[Z].vld || m_ready;
    assign s_ready = adv;

    if (W <= 32) begin : g_in_narrow
        assign op_a_w = s_operand_a[W-1:0];
        assign op_b_w = s_operand_b[W-1:0];
    end else begin : g_in_wide
        assign op_a_w = {{(W-32){s_operand_a[31]}}, s_operand_a};
        assign op_b_w = {{(W-32){s_operand_b[31]}}, s_operand_b};
    end

    if (W >= 32) begin : g_out_narrow
        assign m_result_value = stg_reg[Z].res[31:0];
    end else begin : g_out_wide
        assign m_result_value = {{(32-W){stg_reg[Z].res[W-1]}}, stg_reg[Z].res};
    end

    assign m_valid        = stg_reg[Z].vld;
    assign m_compare_flag = stg_reg[Z].flag;
    assign m_status       = stg_reg[Z].status;

    for (genvar k = 1; k <= Z; k++) begin : g_stage
        if (k == 1) begin : g_capture
            always_comb begin
                stg_next[k]     = '0;
                stg_next[k].vld = s_valid;
                stg_next[k].op  = fpalu_pkg::opcode_t'(s_opcode);
                stg_next[k].a   = op_a_w;
                stg_next[k].b   = op_b_w;
            end
        end else begin : g_work
            localparam int J = NW - (k - 2);
            always_comb begin : p_stage
                stage_t          n;
                logic [NW-1:0]   num;
                logic [W:0]      trial;
                logic [W:0]      fr;
                logic [PW-1:0]   psum;
                logic [H-1:0]    alo;
                logic [H-1:0]    ahi;
                logic [H-1:0]    blo;
                logic [H-1:0]    bhi;
                logic [W-1:0]    m;
                n     = stg_reg[k-1];
                num   = NW'(n.ma) << F;
                trial = '0;
                fr    = '0;
                psum  = '0;
                alo   = H'(n.ma);
                ahi   = H'(n.ma >> H);
                blo   = H'(n.mb);
                bhi   = H'(n.mb >> H);
                m     = '0;
                if (k == 2) begin
                    n.ma     = n.a[W-1] ? (~n.a) + W'(1) : n.a;
                    n.mb     = n.b[W-1] ? (~n.b) + W'(1) : n.b;
                    n.rneg   = (n.op == fpalu_pkg::OP_MUL || n.op == fpalu_pkg::OP_DIV) ?
                               (n.a[W-1] ^ n.b[W-1]) : n.a[W-1];
                    n.res    = '0;
                    n.flag   = 1'b0;
                    n.status = fpalu_pkg::ST_OK;
                    n.rem    = '0;
                    n.quo    = '0;
                    unique case (n.op)
                        fpalu_pkg::OP_ADD: n.res  = n.a + n.b;
                        fpalu_pkg::OP_SUB: n.res  = n.a - n.b;
                        fpalu_pkg::OP_LT:  n.flag = $signed(n.a) < $signed(n.b);
                        fpalu_pkg::OP_GT:  n.flag = $signed(n.b) < $signed(n.a);
                        fpalu_pkg::OP_LE:  n.flag = !($signed(n.b) < $signed(n.a));
                        fpalu_pkg::OP_GE:  n.flag = !($signed(n.a) < $signed(n.b));
                        fpalu_pkg::OP_EQ:  n.flag = (n.a == n.b);
                        fpalu_pkg::OP_NE:  n.flag = (n.a != n.b);
                        fpalu_pkg::OP_MIN: n.res  = ($signed(n.a) < $signed(n.b)) ? n.a : n.b;
                        fpalu_pkg::OP_MAX: n.res  = ($signed(n.b) < $signed(n.a)) ? n.a : n.b;
                        fpalu_pkg::OP_INC: n.res  = n.a + W'(1);
                        fpalu_pkg::OP_DEC: n.res  = n.a - W'(1);
                        default:           n.res  = '0;
                    endcase
                end
                if (k >= 3 && k <= D + 2) begin
                    trial = {n.rem, num[J]};
                    if (trial >= {1'b0, n.mb}) begin
                        n.rem = W'(trial - {1'b0, n.mb});
                        n.quo = {n.quo[NW-2:0], 1'b1};
                    end else begin
                        n.rem = trial[W-1:0];
                        n.quo = {n.quo[NW-2:0], 1'b0};
                    end
                end
                if (k == 3) begin
                    n.pll = {{H{1'b0}}, alo} * {{H{1'b0}}, blo};
                    n.plh = {{H{1'b0}}, alo} * {{H{1'b0}}, bhi};
                    n.phl = {{H{1'b0}}, ahi} * {{H{1'b0}}, blo};
                    n.phh = {{H{1'b0}}, ahi} * {{H{1'b0}}, bhi};
                    if (n.op == fpalu_pkg::OP_I2F) begin
                        fr    = fit(n.rneg, MW'(num));
                        n.res = fr[W-1:0];
                        if (fr[W]) begin
                            n.status = fpalu_pkg::ST_SAT;
                        end
                    end
                    if (n.op == fpalu_pkg::OP_F2I) begin
                        m     = n.ma >> F;
                        n.res = n.rneg ? (~m) + W'(1) : m;
                    end
                end
                if (k == 4) begin
                    psum   = PW'(n.pll) + (PW'(n.plh) << H) + (PW'(n.phl) << H)
                           + (PW'(n.phh) << (2 * H));
                    n.prod = (2*W)'(psum);
                end
                if (k == 5 && n.op == fpalu_pkg::OP_MUL) begin
                    fr    = fit(n.rneg, MW'(n.prod >> F));
                    n.res = fr[W-1:0];
                    if (fr[W]) begin
                        n.status = fpalu_pkg::ST_SAT;
                    end
                end
                if (k == Z && n.op == fpalu_pkg::OP_DIV) begin
                    if (n.mb == '0) begin
                        n.res    = '0;
                        n.status = fpalu_pkg::ST_DIV0;
                    end else begin
                        fr    = fit(n.rneg, MW'(n.quo));
                        n.res = fr[W-1:0];
                        if (fr[W]) begin
                            n.status = fpalu_pkg::ST_SAT;
                        end
                    end
                end
                stg_next[k] = n;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[k].vld <= 1'b0;
            end else if (adv) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

`include "fixed_point_alu_assert.svh"

    `FPALU_ASSERT_NEXT(a_stall_holds, m_valid && !m_ready, m_valid && $stable(m_result_value) && $stable(m_status))
    `FPALU_ASSERT_SAME(a_flag_cmp_only, m_valid && m_compare_flag, stg_reg[Z].op >= fpalu_pkg::OP_LT && stg_reg[Z].op <= fpalu_pkg::OP_NE)
    `FPALU_ASSERT_SAME(a_div0_zero, m_valid && m_status == fpalu_pkg::ST_DIV0, stg_reg[Z].op == fpalu_pkg::OP_DIV && m_result_value == 32'sd0)

endmodule

### tb/tb_top.sv
// Self-checking testbench for the pipelined fixed-point ALU.
`timescale 1ns / 100ps

class alu_scoreboard;
    logic [31:0] exp_value[$];
    logic        exp_flag[$];
    logic [1:0]  exp_status[$];
    int          errors;
    int          checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    // Saturate a magnitude with a sign to the 32-bit range.
    static function logic [31:0] clamp(bit neg, logic [127:0] m, output logic [1:0] st);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (m > lim) begin
            st = fpalu_pkg::ST_SAT;
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return neg ? (32'd0 - m[31:0]) : m[31:0];
    endfunction

    function void note_operation(fpalu_pkg::opcode_t op, logic signed [31:0] a,
                                 logic signed [31:0] b);
        logic [31:0]  r;
        logic         f;
        logic [1:0]   st;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        bit           neg;
        r  = '0;
        f  = 1'b0;
        st = fpalu_pkg::ST_OK;
        ma = a[31] ? -64'(a) : 64'(a);
        mb = b[31] ? -64'(b) : 64'(b);
        neg = a[31] ^ b[31];
        case (op)
            fpalu_pkg::OP_ADD: r = a + b;
            fpalu_pkg::OP_SUB: r = a - b;
            fpalu_pkg::OP_MUL: begin
                p = (128'(ma) * 128'(mb)) >> 8;
                r = clamp(neg, p, st);
            end
            fpalu_pkg::OP_DIV: begin
                if (b == 0) begin
                    st = fpalu_pkg::ST_DIV0;
                end else begin
                    p = (128'(ma) << 8) / 128'(mb);
                    r = clamp(neg, p, st);
                end
            end
            fpalu_pkg::OP_LT:  f = a < b;
            fpalu_pkg::OP_GT:  f = a > b;
            fpalu_pkg::OP_LE:  f = a <= b;
            fpalu_pkg::OP_GE:  f = a >= b;
            fpalu_pkg::OP_EQ:  f = a == b;
            fpalu_pkg::OP_NE:  f = a != b;
            fpalu_pkg::OP_MIN: r = (a < b) ? a : b;
            fpalu_pkg::OP_MAX: r = (b < a) ? a : b;
            fpalu_pkg::OP_INC: r = a + 1;
            fpalu_pkg::OP_DEC: r = a - 1;
            fpalu_pkg::OP_I2F: r = clamp(a[31], 128'(ma) << 8, st);
            default: begin
                p = 128'(ma >> 8);
                r = a[31] ? (32'd0 - p[31:0]) : p[31:0];
            end
        endcase
        exp_value.push_back(r);
        exp_flag.push_back(f);
        exp_status.push_back(st);
    endfunction

    function void check_result(logic [31:0] v, logic f, logic [1:0] st);
        logic [31:0] ev;
        logic        ef;
        logic [1:0]  es;
        if (exp_value.size() == 0) begin
            $display("%0t: result beat with nothing expected: value %h", $time, v);
            errors++;
            return;
        end
        ev = exp_value.pop_front();
        ef = exp_flag.pop_front();
        es = exp_status.pop_front();
        checked++;
        if (v !== ev) begin
            $display("%0t: result_value expected %h actual %h", $time, ev, v);
            errors++;
        end
        if (f !== ef) begin
            $display("%0t: compare_flag expected %b actual %b", $time, ef, f);
            errors++;
        end
        if (st !== es) begin
            $display("%0t: status expected %0d actual %0d", $time, es, st);
            errors++;
        end
    endfunction
endclass

module tb_top;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_opcode = '0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_result_value;
    logic               m_compare_flag;
    logic [1:0]         m_status;

    alu_scoreboard sb = new();
    bit busy_mode = 1'b1;
    int sent = 0;

    fixed_point_alu u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value),
        .m_compare_flag(m_compare_flag), .m_status(m_status)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_operation(fpalu_pkg::opcode_t'(s_opcode), s_operand_a, s_operand_b);
            sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_result_value, m_compare_flag, m_status);
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && (!busy_mode || $urandom_range(99) >= 31);
    end

    // The beat stays valid after acceptance until an idle cycle or the caller drops it.
    task automatic send_op(fpalu_pkg::opcode_t op, logic [31:0] a, logic [31:0] b);
        while (busy_mode && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(0, 1023)) - 512);
            2: return 32'($signed($urandom_range(0, 2047)) - 1024) << 8;
            3: return $urandom() >> $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] edges[6];
        int k;
        edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd256, 32'h0080_0000};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int op = 0; op < 16; op++) begin
            send_op(fpalu_pkg::opcode_t'(op), edges[op % 6], edges[(op + 1) % 6]);
        end
        send_op(fpalu_pkg::OP_DIV, 32'd1000, 32'd0);
        send_op(fpalu_pkg::OP_MIN, 32'd77, 32'd77);
        send_op(fpalu_pkg::OP_MAX, 32'h8000_0000, 32'h8000_0000);
        send_op(fpalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(fpalu_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_op(fpalu_pkg::OP_I2F, 32'hFF80_0000, 32'd0);
        send_op(fpalu_pkg::OP_F2I, 32'hFFFF_FF01, 32'd0);
        s_valid <= 1'b0;
        while (sb.exp_value.size() != 0) begin
            @(negedge aclk);
        end
        for (k = 0; k < 750; k++) begin
            busy_mode = !(k >= 200 && k < 320);
            send_op(fpalu_pkg::opcode_t'($urandom_range(15)), pick_operand(), pick_operand());
        end
        s_valid <= 1'b0;
        busy_mode = 1'b1;
        while (sb.exp_value.size() != 0) begin
            @(negedge aclk);
        end
        repeat (60) @(negedge aclk);
        $display("Ran %0d operations over all sixteen opcodes, %0d results checked,",
                 sent, sb.checked);
        $display("with operand extremes, saturation and division by zero included.");
        if (sb.errors == 0 && sb.exp_value.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
